@@ rtl/epoch_seconds_to_calendar_macros.svh @@
// Assertion macros for the checker file of the epoch-to-calendar block.
`ifndef EPOCH_SECONDS_TO_CALENDAR_MACROS_SVH
`define EPOCH_SECONDS_TO_CALENDAR_MACROS_SVH

// Check on every rising edge of clk_i, skip while rst_ni is low.
`define ESC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check on every rising edge of clk_i, reset included.
`define ESC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

@@ rtl/esc_pkg.sv @@
// Widths, calendar spans, reciprocals and month tables of the epoch-to-calendar block.
`default_nettype none

package esc_pkg;

  localparam int unsigned SECONDS_WIDTH = 40;
  localparam int unsigned IN_TDATA_W    = 40;
  localparam int unsigned OUT_TDATA_W   = 56;

  // Seconds since 1601-01-01, one bit wider than the input count.
  localparam int unsigned       SEC_W       = SECONDS_WIDTH + 1;
  localparam logic [SEC_W-1:0]  REBIAS_1601 = SEC_W'(64'd11644473600);

  // 86400 = 675 << 7: drop seven bits, then divide by 675 in two chunks.
  localparam int unsigned SECONDS_PER_DAY = 86400;
  localparam int unsigned DAY_SHIFT       = 7;
  localparam int unsigned DAY_ODD         = SECONDS_PER_DAY >> DAY_SHIFT;
  localparam int unsigned X_W             = SEC_W - DAY_SHIFT;
  localparam int unsigned XL_W            = 17;
  localparam int unsigned XH_W            = X_W - XL_W;
  localparam int unsigned QH_W            = 8;
  localparam int unsigned RH_W            = $clog2(DAY_ODD);
  localparam int unsigned N_W             = RH_W + XL_W;
  localparam int unsigned DAY_W           = QH_W + XL_W;
  localparam int unsigned SOD_W           = RH_W + DAY_SHIFT;

  localparam int unsigned SEC_PER_MIN   = 60;
  localparam int unsigned MIN_PER_HOUR  = 60;
  localparam int unsigned DAYS_PER_WEEK = 7;
  localparam int unsigned MT_W          = 11;
  localparam int unsigned Q7_W          = 23;

  localparam int unsigned SPAN_400Y_DAYS = 146097;
  localparam int unsigned SPAN_100Y_DAYS = 36524;
  localparam int unsigned SPAN_4Y_DAYS   = 1461;
  localparam int unsigned SPAN_1Y_DAYS   = 365;
  localparam int unsigned Q400_W         = 8;
  localparam int unsigned Q100_MAX       = 3;
  localparam int unsigned Q4_MAX         = 24;
  localparam int unsigned BASE_YEAR      = 1601;
  localparam int unsigned YEAR_REF       = 1900;
  localparam int unsigned YEAR_BIAS      = YEAR_REF - BASE_YEAR;

  // Reciprocals ceil(2^K / d); K = bits of dividend + bits of d keeps the quotient exact.
  localparam int unsigned       RCP_675_HI_K = XH_W + RH_W;
  localparam int unsigned       RCP_675_HI_W = 18;
  localparam logic [RCP_675_HI_W-1:0] RCP_675_HI =
    RCP_675_HI_W'(((64'd1 << RCP_675_HI_K) + 64'(DAY_ODD) - 64'd1) / 64'(DAY_ODD));

  localparam int unsigned       RCP_675_LO_K = N_W + RH_W;
  localparam int unsigned       RCP_675_LO_W = 28;
  localparam logic [RCP_675_LO_W-1:0] RCP_675_LO =
    RCP_675_LO_W'(((64'd1 << RCP_675_LO_K) + 64'(DAY_ODD) - 64'd1) / 64'(DAY_ODD));

  localparam int unsigned       RCP_7_K = DAY_W + 3;
  localparam int unsigned       RCP_7_W = 26;
  localparam logic [RCP_7_W-1:0] RCP_7 =
    RCP_7_W'(((64'd1 << RCP_7_K) + 64'(DAYS_PER_WEEK) - 64'd1) / 64'(DAYS_PER_WEEK));

  localparam int unsigned       RCP_SOD_K = SOD_W + 6;
  localparam int unsigned       RCP_SOD_W = 18;
  localparam logic [RCP_SOD_W-1:0] RCP_SOD =
    RCP_SOD_W'(((64'd1 << RCP_SOD_K) + 64'(SEC_PER_MIN) - 64'd1) / 64'(SEC_PER_MIN));

  localparam int unsigned       RCP_MIN_K = MT_W + 6;
  localparam int unsigned       RCP_MIN_W = 12;
  localparam logic [RCP_MIN_W-1:0] RCP_MIN =
    RCP_MIN_W'(((64'd1 << RCP_MIN_K) + 64'(MIN_PER_HOUR) - 64'd1) / 64'(MIN_PER_HOUR));

  localparam int unsigned       RCP_400Y_K = DAY_W + 18;
  localparam int unsigned       RCP_400Y_W = 26;
  localparam logic [RCP_400Y_W-1:0] RCP_400Y =
    RCP_400Y_W'(((64'd1 << RCP_400Y_K) + 64'(SPAN_400Y_DAYS) - 64'd1) / 64'(SPAN_400Y_DAYS));

  localparam int unsigned       RCP_100Y_K = 18 + 16;
  localparam int unsigned       RCP_100Y_W = 19;
  localparam logic [RCP_100Y_W-1:0] RCP_100Y =
    RCP_100Y_W'(((64'd1 << RCP_100Y_K) + 64'(SPAN_100Y_DAYS) - 64'd1) / 64'(SPAN_100Y_DAYS));

  localparam int unsigned       RCP_4Y_K = 16 + 11;
  localparam int unsigned       RCP_4Y_W = 17;
  localparam logic [RCP_4Y_W-1:0] RCP_4Y =
    RCP_4Y_W'(((64'd1 << RCP_4Y_K) + 64'(SPAN_4Y_DAYS) - 64'd1) / 64'(SPAN_4Y_DAYS));

  // Pipeline depth; the date part owns the last DATE_STAGES stages.
  localparam int unsigned DATE_FIRST  = 5;
  localparam int unsigned DATE_STAGES = 8;
  localparam int unsigned STAGES      = DATE_FIRST + DATE_STAGES;

  // Days before the first of each month, common year then leap year.
  localparam logic [8:0] CUM_DAYS [2][13] = '{
    '{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181, 9'd212, 9'd243, 9'd273, 9'd304,
      9'd334, 9'd365},
    '{9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152, 9'd182, 9'd213, 9'd244, 9'd274, 9'd305,
      9'd335, 9'd366}
  };

endpackage

`default_nettype wire

@@ rtl/esc_date.sv @@
// Day count since 1601-01-01 to years since 1900, month, day of month and day of year, eight stages.
`default_nettype none

module esc_date
  import esc_pkg::*;
(
  input  logic                   clk_i,
  input  logic [DATE_STAGES-1:0] stage_en_i,
  input  logic [DAY_W-1:0]       days_i,
  output logic [15:0]            years_o,
  output logic [3:0]             month_o,
  output logic [4:0]             mday_o,
  output logic [8:0]             yday_o
);

  localparam int unsigned P400_W = DAY_W + RCP_400Y_W;
  localparam int unsigned P100_W = 18 + RCP_100Y_W;
  localparam int unsigned P4_W   = 16 + RCP_4Y_W;

  logic [DAY_W-1:0]  days0_q;
  logic [Q400_W-1:0] q400_0_q, q400_1_q, q400_2_q, q400_3_q, q400_4_q, q400_5_q;
  logic [17:0]       d400_1_q, d400_2_q;
  logic [1:0]        q100_2_q, q100_3_q, q100_4_q, q100_5_q;
  logic [15:0]       d100_3_q, d100_4_q;
  logic [4:0]        q4_4_q, q4_5_q;
  logic [10:0]       d4_5_q;
  logic [8:0]        yday6_q;
  logic              leap6_q;
  logic [15:0]       years6_q;

  logic [P400_W-1:0] p400;
  logic [P100_W-1:0] p100;
  logic [P4_W-1:0]   p4;
  logic [2:0]        q100_raw;
  logic [1:0]        q100_d;
  logic [4:0]        q4_raw, q4_d;
  logic [1:0]        q1_d;
  logic [8:0]        yday_d;
  logic              leap_d;
  logic [17:0]       years_sum;
  logic [3:0]        month_d;
  logic [4:0]        mday_d;

  assign p400 = P400_W'(days_i) * P400_W'(RCP_400Y);
  assign p100 = P100_W'(d400_1_q) * P100_W'(RCP_100Y);
  assign p4   = P4_W'(d100_3_q) * P4_W'(RCP_4Y);

  // Clamp so the last day of a cycle stays in its final year.
  assign q100_raw = p100[RCP_100Y_K +: 3];
  assign q100_d   = (q100_raw > 3'(Q100_MAX)) ? 2'(Q100_MAX) : q100_raw[1:0];
  assign q4_raw   = p4[RCP_4Y_K +: 5];
  assign q4_d     = (q4_raw > 5'(Q4_MAX)) ? 5'(Q4_MAX) : q4_raw;

  always_comb begin
    if (d4_5_q >= 11'(3 * SPAN_1Y_DAYS)) begin
      q1_d = 2'd3;
    end else if (d4_5_q >= 11'(2 * SPAN_1Y_DAYS)) begin
      q1_d = 2'd2;
    end else if (d4_5_q >= 11'(SPAN_1Y_DAYS)) begin
      q1_d = 2'd1;
    end else begin
      q1_d = 2'd0;
    end
  end

  assign yday_d = 9'(d4_5_q - 11'(q1_d) * 11'(SPAN_1Y_DAYS));
  // Fourth year of a 4-year span, unless it closes a century that is not the fourth.
  assign leap_d = (q1_d == 2'd3) && ((q4_5_q != 5'(Q4_MAX)) || (q100_5_q == 2'(Q100_MAX)));
  assign years_sum = 18'(q400_5_q) * 18'd400 + 18'(q100_5_q) * 18'd100
                   + 18'(q4_5_q) * 18'd4 + 18'(q1_d) - 18'(YEAR_BIAS);

  always_comb begin
    month_d = 4'd11;
    for (int m = 12; m >= 1; m--) begin
      if (yday6_q < CUM_DAYS[leap6_q][m]) begin
        month_d = 4'(m - 1);
      end
    end
    mday_d = 5'(yday6_q - CUM_DAYS[leap6_q][month_d] + 9'd1);
  end

  always_ff @(posedge clk_i) begin
    if (stage_en_i[0]) begin
      days0_q  <= days_i;
      q400_0_q <= p400[RCP_400Y_K +: Q400_W];
    end
    if (stage_en_i[1]) begin
      q400_1_q <= q400_0_q;
      d400_1_q <= 18'(days0_q - DAY_W'(q400_0_q) * DAY_W'(SPAN_400Y_DAYS));
    end
    if (stage_en_i[2]) begin
      q400_2_q <= q400_1_q;
      q100_2_q <= q100_d;
      d400_2_q <= d400_1_q;
    end
    if (stage_en_i[3]) begin
      q400_3_q <= q400_2_q;
      q100_3_q <= q100_2_q;
      d100_3_q <= 16'(d400_2_q - 18'(q100_2_q) * 18'(SPAN_100Y_DAYS));
    end
    if (stage_en_i[4]) begin
      q400_4_q <= q400_3_q;
      q100_4_q <= q100_3_q;
      q4_4_q   <= q4_d;
      d100_4_q <= d100_3_q;
    end
    if (stage_en_i[5]) begin
      q400_5_q <= q400_4_q;
      q100_5_q <= q100_4_q;
      q4_5_q   <= q4_4_q;
      d4_5_q   <= 11'(d100_4_q - 16'(q4_4_q) * 16'(SPAN_4Y_DAYS));
    end
    if (stage_en_i[6]) begin
      yday6_q  <= yday_d;
      leap6_q  <= leap_d;
      years6_q <= years_sum[15:0];
    end
    if (stage_en_i[7]) begin
      years_o <= years6_q;
      month_o <= month_d;
      mday_o  <= mday_d;
      yday_o  <= yday6_q;
    end
  end

endmodule

`default_nettype wire

@@ rtl/epoch_seconds_to_calendar.sv @@
// Top level: Unix epoch seconds to Gregorian UTC calendar fields, thirteen-stage pipeline.
//
// Requests arrive on the s_axis channel, one 40-bit count of seconds since
// 1970-01-01 00:00:00 UTC per beat; results leave on m_axis, one per request,
// in request order.
// Throughput: one request per cycle while m_axis_tready_i is high. Every divide
// is a multiply by a constant reciprocal followed by a remainder stage; the day
// count to year chain (400-, 100-, 4- and 1-year spans) sets the depth.
// Each stage holds a valid bit. A stage loads whenever it is empty or the
// stage after it loads, so bubbles close up and s_axis_tready_o stays high
// while any stage is free, also while a result waits on m_axis.
// When the receiver stalls, the output register holds its result and the
// pipeline fills behind it; nothing is dropped or repeated.
// Reset (rst_ni low, asynchronous) empties every stage; no result is pending
// after reset and the block takes requests in the first cycle after release.
`default_nettype none

module epoch_seconds_to_calendar
  import esc_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,   // [39:0] epoch_seconds
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // [5:0] second_of_minute, [11:6] minute_of_hour, [16:12] hour_of_day,
  // [21:17] day_of_month, [25:22] month_index, [41:26] years_since_1900,
  // [44:42] day_of_week, [53:45] day_of_year, [55:54] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o
);

  typedef struct packed {
    logic [5:0] sec;
    logic [5:0] min;
    logic [4:0] hour;
    logic [2:0] wday;
  } esc_clock_t;

  localparam int unsigned PQH_W  = XH_W + RCP_675_HI_W;
  localparam int unsigned PQL_W  = N_W + RCP_675_LO_W;
  localparam int unsigned PQ7_W  = DAY_W + RCP_7_W;
  localparam int unsigned PMT_W  = SOD_W + RCP_SOD_W;
  localparam int unsigned PHR_W  = MT_W + RCP_MIN_W;
  localparam int unsigned TAIL_N = STAGES - 9;

  logic [STAGES-1:0] vld_q, vld_d, adv;

  logic [SEC_W-1:0]     s0_q;
  logic [XH_W-1:0]      xh1_q;
  logic [QH_W-1:0]      qh1_q, qh2_q, qh3_q;
  logic [XL_W-1:0]      xl1_q, ql3_q;
  logic [DAY_SHIFT-1:0] lo1_q, lo2_q, lo3_q;
  logic [N_W-1:0]       n2_q, n3_q;
  logic [DAY_W-1:0]     days4_q, days5_q;
  logic [SOD_W-1:0]     sod4_q, sod5_q;
  logic [MT_W-1:0]      mt5_q, mt6_q, mt7_q;
  logic [Q7_W-1:0]      q7_5_q;
  logic [5:0]           sec6_q, sec7_q;
  logic [2:0]           wday6_q, wday7_q;
  logic [4:0]           hr7_q;
  esc_clock_t           clk_pipe_q [TAIL_N+1];

  logic [X_W-1:0]   x0;
  logic [PQH_W-1:0] pqh;
  logic [XH_W-1:0]  rh_full;
  logic [PQL_W-1:0] pql;
  logic [N_W-1:0]   sodhi_full;
  logic [PQ7_W-1:0] pq7;
  logic [PMT_W-1:0] pmt;
  logic [PHR_W-1:0] phr;
  logic [2:0]       wrem;
  esc_clock_t       clk8_d;

  logic [15:0] years;
  logic [3:0]  month;
  logic [4:0]  mday;
  logic [8:0]  yday;

  // Stage k loads when it is empty or some later stage (or the receiver) frees a slot.
  always_comb begin
    for (int k = 0; k < STAGES; k++) begin
      adv[k] = m_axis_tready_i || !(&(vld_q | STAGES'((64'd1 << k) - 64'd1)));
    end
    vld_d = {vld_q[STAGES-2:0], s_axis_tvalid_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < STAGES; k++) begin
        if (adv[k]) begin
          vld_q[k] <= vld_d[k];
        end
      end
    end
  end

  assign s_axis_tready_o = adv[0];

  // Seconds to day count: drop the power-of-two factor, divide by 675 high chunk first.
  assign x0         = s0_q[SEC_W-1:DAY_SHIFT];
  assign pqh        = PQH_W'(x0[X_W-1:XL_W]) * PQH_W'(RCP_675_HI);
  assign rh_full    = xh1_q - XH_W'(qh1_q) * XH_W'(DAY_ODD);
  assign pql        = PQL_W'(n2_q) * PQL_W'(RCP_675_LO);
  assign sodhi_full = n3_q - N_W'(ql3_q) * N_W'(DAY_ODD);

  // Time of day and weekday.
  assign pq7  = PQ7_W'(days4_q) * PQ7_W'(RCP_7);
  assign pmt  = PMT_W'(sod4_q) * PMT_W'(RCP_SOD);
  assign phr  = PHR_W'(mt6_q) * PHR_W'(RCP_MIN);
  assign wrem = 3'(days5_q - DAY_W'(q7_5_q) * DAY_W'(DAYS_PER_WEEK));

  always_comb begin
    clk8_d.sec  = sec7_q;
    clk8_d.min  = 6'(mt7_q - MT_W'(hr7_q) * MT_W'(MIN_PER_HOUR));
    clk8_d.hour = hr7_q;
    clk8_d.wday = wday7_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      s0_q <= SEC_W'(s_axis_tdata_i[SECONDS_WIDTH-1:0]) + REBIAS_1601;
    end
    if (adv[1]) begin
      xh1_q <= x0[X_W-1:XL_W];
      qh1_q <= pqh[RCP_675_HI_K +: QH_W];
      xl1_q <= x0[XL_W-1:0];
      lo1_q <= s0_q[DAY_SHIFT-1:0];
    end
    if (adv[2]) begin
      n2_q  <= {rh_full[RH_W-1:0], xl1_q};
      qh2_q <= qh1_q;
      lo2_q <= lo1_q;
    end
    if (adv[3]) begin
      n3_q  <= n2_q;
      qh3_q <= qh2_q;
      ql3_q <= pql[RCP_675_LO_K +: XL_W];
      lo3_q <= lo2_q;
    end
    if (adv[4]) begin
      days4_q <= {qh3_q, ql3_q};
      sod4_q  <= {sodhi_full[RH_W-1:0], lo3_q};
    end
    if (adv[5]) begin
      days5_q <= days4_q;
      q7_5_q  <= pq7[RCP_7_K +: Q7_W];
      sod5_q  <= sod4_q;
      mt5_q   <= pmt[RCP_SOD_K +: MT_W];
    end
    if (adv[6]) begin
      mt6_q   <= mt5_q;
      sec6_q  <= 6'(sod5_q - SOD_W'(mt5_q) * SOD_W'(SEC_PER_MIN));
      // 1601-01-01 was a Monday: shift the remainder by one day.
      wday6_q <= (wrem == 3'(DAYS_PER_WEEK - 1)) ? 3'd0 : wrem + 3'd1;
    end
    if (adv[7]) begin
      mt7_q   <= mt6_q;
      hr7_q   <= phr[RCP_MIN_K +: 5];
      sec7_q  <= sec6_q;
      wday7_q <= wday6_q;
    end
    if (adv[8]) begin
      clk_pipe_q[0] <= clk8_d;
    end
    for (int i = 1; i <= TAIL_N; i++) begin
      if (adv[8 + i]) begin
        clk_pipe_q[i] <= clk_pipe_q[i-1];
      end
    end
  end

  esc_date u_date (
    .clk_i      (clk_i),
    .stage_en_i (adv[STAGES-1:DATE_FIRST]),
    .days_i     (days4_q),
    .years_o    (years),
    .month_o    (month),
    .mday_o     (mday),
    .yday_o     (yday)
  );

  assign m_axis_tvalid_o = vld_q[STAGES-1];
  assign m_axis_tdata_o  = {2'b00, yday, clk_pipe_q[TAIL_N].wday, years, month, mday,
                            clk_pipe_q[TAIL_N].hour, clk_pipe_q[TAIL_N].min,
                            clk_pipe_q[TAIL_N].sec};

endmodule

`default_nettype wire

@@ rtl/esc_checker.sv @@
// Port-level checks of the epoch-to-calendar block and their bind to the top level.
`default_nettype none
`include "epoch_seconds_to_calendar_macros.svh"

module esc_checker
  import esc_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tready_o,
  input logic                   m_axis_tvalid_o,
  input logic                   m_axis_tready_i,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata_o
);

  logic [5:0] sec;
  logic [5:0] min;
  logic [4:0] hour;
  logic [4:0] mday;
  logic [3:0] month;
  logic [2:0] wday;
  logic [8:0] yday;

  assign sec   = m_axis_tdata_o[5:0];
  assign min   = m_axis_tdata_o[11:6];
  assign hour  = m_axis_tdata_o[16:12];
  assign mday  = m_axis_tdata_o[21:17];
  assign month = m_axis_tdata_o[25:22];
  assign wday  = m_axis_tdata_o[44:42];
  assign yday  = m_axis_tdata_o[53:45];

  `ESC_ASSERT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o), "stalled result changed")
  `ESC_ASSERT(a_field_range, m_axis_tvalid_o |-> (sec < 6'd60) && (min < 6'd60) && (hour < 5'd24) && (mday != 5'd0) && (month < 4'd12) && (wday < 3'd7) && (yday <= 9'd365), "result field out of range")
  `ESC_ASSERT(a_january_days, m_axis_tvalid_o && (month == 4'd0) |-> (yday == 9'(mday) - 9'd1), "January day of year does not match day of month")
  `ESC_ASSERT(a_free_when_empty, !m_axis_tvalid_o |-> s_axis_tready_o, "input blocked with no result pending")
  // Flops are unknown before the first reset edge, so check in the next cycle.
  `ESC_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !m_axis_tvalid_o, "result valid after reset")

endmodule

bind epoch_seconds_to_calendar esc_checker u_esc_checker (.*);

`default_nettype wire

@@ test/tb.sv @@
// Testbench for epoch_seconds_to_calendar: random-stall stream checked against a date predictor.
`default_nettype none

module tb;
  import esc_pkg::*;

  typedef struct packed {
    logic [8:0]  day_of_year;
    logic [2:0]  day_of_week;
    logic [15:0] years_since_1900;
    logic [3:0]  month_index;
    logic [4:0]  day_of_month;
    logic [4:0]  hour_of_day;
    logic [5:0]  minute_of_hour;
    logic [5:0]  second_of_minute;
  } calendar_t;

  localparam longint unsigned SECS_TO_1970 = 64'd11644473600;
  localparam longint unsigned SECS_400Y    = 64'd12622780800;
  localparam longint unsigned SECS_100Y    = 64'd3155673600;
  localparam longint unsigned SECS_4Y      = 64'd126230400;
  localparam longint unsigned SECS_1Y      = 64'd31536000;
  localparam longint unsigned SECS_DAY     = 64'd86400;
  localparam longint unsigned FIRST_YEAR   = 64'd1601;
  localparam int unsigned     RANDOM_ITEMS = 1750;
  localparam int unsigned     DRAIN_CYCLES = 20;

  localparam int unsigned MONTH_START [2][13] = '{
    '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365},
    '{0, 31, 60, 91, 121, 152, 182, 213, 244, 274, 305, 335, 366}
  };

  logic                   clk_i           = 1'b0;
  logic                   rst_ni          = 1'b0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_axis_tdata_i  = '0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;

  logic [39:0] pending_stamps [$];
  calendar_t   expected_dates [$];
  bit          failed;
  int unsigned cycle_count;
  logic        steady;

  epoch_seconds_to_calendar dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  // Break the count into calendar fields, working from the 1601 epoch.
  function automatic calendar_t to_calendar(logic [39:0] secs);
    longint unsigned s, wday, q400, q100, q4, q1, year, yday, hour, minute;
    int unsigned leap, month;
    bit found;
    calendar_t r;
    s    = 64'(secs) + SECS_TO_1970;
    wday = (s / SECS_DAY + 1) % 7;
    q400 = s / SECS_400Y;
    s    = s % SECS_400Y;
    q100 = s / SECS_100Y;
    if (q100 > 3) q100 = 3;
    s    = s - q100 * SECS_100Y;
    q4   = s / SECS_4Y;
    if (q4 > 24) q4 = 24;
    s    = s - q4 * SECS_4Y;
    q1   = s / SECS_1Y;
    if (q1 > 3) q1 = 3;
    s    = s - q1 * SECS_1Y;
    year = FIRST_YEAR + q400 * 400 + q100 * 100 + q4 * 4 + q1;
    leap = (year % 4 == 0 && (year % 100 != 0 || year % 400 == 0)) ? 1 : 0;
    yday   = s / SECS_DAY;
    s      = s % SECS_DAY;
    hour   = s / 3600;
    s      = s % 3600;
    minute = s / 60;
    s      = s % 60;
    month = 11;
    found = 1'b0;
    for (int m = 1; m < 13; m++) begin
      if (!found && yday < MONTH_START[leap][m]) begin
        month = m - 1;
        found = 1'b1;
      end
    end
    r.second_of_minute = 6'(s);
    r.minute_of_hour   = 6'(minute);
    r.hour_of_day      = 5'(hour);
    r.day_of_month     = 5'(yday - MONTH_START[leap][month] + 1);
    r.month_index      = 4'(month);
    r.years_since_1900 = 16'(year - 1900);
    r.day_of_week      = 3'(wday);
    r.day_of_year      = 9'(yday);
    return r;
  endfunction

  // Seconds since 1970 for a civil date and time (year 1970 or later).
  function automatic logic [39:0] stamp(int y, int mo, int d, int h, int mi, int sec);
    longint era, yoe, doy, doe, days;
    if (mo <= 2) y = y - 1;
    era  = y / 400;
    yoe  = y - era * 400;
    doy  = (153 * (mo > 2 ? mo - 3 : mo + 9) + 2) / 5 + d - 1;
    doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    days = era * 146097 + doe - 719468;
    return 40'(days * 86400 + h * 3600 + mi * 60 + sec);
  endfunction

  task automatic check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      failed = 1'b1;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endtask

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end
  assign steady = (cycle_count >= 1000 && cycle_count < 1600);

  // Feed requests; pull the next one only once the current one is taken.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        expected_dates.push_back(to_calendar(s_axis_tdata_i));
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (pending_stamps.size() != 0 && (steady || $urandom_range(99) >= 35)) begin
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= pending_stamps.pop_front();
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= steady || $urandom_range(99) >= 35;
    end
  end

  always @(posedge clk_i) begin
    calendar_t got, want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = calendar_t'(m_axis_tdata_o[53:0]);
      if (expected_dates.size() == 0) begin
        failed = 1'b1;
        $error("result with no request outstanding: tdata %h", m_axis_tdata_o);
      end else begin
        want = expected_dates.pop_front();
        check_field("second_of_minute", want.second_of_minute, got.second_of_minute);
        check_field("minute_of_hour", want.minute_of_hour, got.minute_of_hour);
        check_field("hour_of_day", want.hour_of_day, got.hour_of_day);
        check_field("day_of_month", want.day_of_month, got.day_of_month);
        check_field("month_index", want.month_index, got.month_index);
        check_field("years_since_1900", want.years_since_1900, got.years_since_1900);
        check_field("day_of_week", want.day_of_week, got.day_of_week);
        check_field("day_of_year", want.day_of_year, got.day_of_year);
        check_field("tdata padding", 0, m_axis_tdata_o[55:54]);
      end
    end
  end

  initial begin
    logic [63:0] raw;
    int          y;
    failed      = 1'b0;
    cycle_count = 0;

    // Field extremes, leap days, and the span clamps at cycle, century and year ends.
    pending_stamps.push_back(40'd0);
    pending_stamps.push_back({40{1'b1}});
    pending_stamps.push_back(40'hAA_AAAA_AAAA);
    pending_stamps.push_back(40'h55_5555_5555);
    pending_stamps.push_back(40'h00_7FFF_FFFF);
    pending_stamps.push_back(40'h00_8000_0000);
    pending_stamps.push_back(40'h00_FFFF_FFFF);
    pending_stamps.push_back(40'h01_0000_0000);
    pending_stamps.push_back(stamp(1972, 2, 29, 12, 34, 56));
    pending_stamps.push_back(stamp(1972, 12, 31, 23, 59, 59));
    pending_stamps.push_back(stamp(1973, 1, 1, 0, 0, 0));
    pending_stamps.push_back(stamp(1999, 12, 31, 23, 59, 59));
    pending_stamps.push_back(stamp(2000, 2, 29, 0, 0, 0));
    pending_stamps.push_back(stamp(2000, 12, 31, 23, 59, 59));
    pending_stamps.push_back(stamp(2001, 1, 1, 0, 0, 0));
    pending_stamps.push_back(stamp(2100, 2, 28, 23, 59, 59));
    pending_stamps.push_back(stamp(2100, 3, 1, 0, 0, 0));
    pending_stamps.push_back(stamp(2100, 12, 31, 18, 30, 0));
    pending_stamps.push_back(stamp(2104, 12, 31, 23, 59, 59));
    pending_stamps.push_back(stamp(2400, 2, 29, 6, 7, 8));
    pending_stamps.push_back(stamp(2400, 12, 31, 23, 59, 59));
    pending_stamps.push_back(stamp(2024, 7, 4, 9, 15, 30));
    pending_stamps.push_back(stamp(2023, 11, 30, 1, 2, 3));

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      case ($urandom_range(0, 4))
        0: begin
          raw = {$urandom(), $urandom()};
          pending_stamps.push_back(raw[39:0]);
        end
        1: begin
          y = $urandom_range(1970, 36000);
          if ($urandom_range(0, 1) == 0) pending_stamps.push_back(stamp(y, 12, 31, 23, 59, 59));
          else pending_stamps.push_back(stamp(y, 1, 1, 0, 0, 0));
        end
        2: begin
          y = 100 * $urandom_range(20, 360);
          case ($urandom_range(0, 3))
            0: pending_stamps.push_back(stamp(y, 2, 28, 23, 59, 59));
            1: pending_stamps.push_back(stamp(y, 3, 1, 0, 0, 0));
            2: pending_stamps.push_back(stamp(y, 12, 31, $urandom_range(0, 23),
                                              $urandom_range(0, 59), $urandom_range(0, 59)));
            default: pending_stamps.push_back(stamp((y % 400 == 0) ? y : y + 4, 2, 29,
                                              $urandom_range(0, 23), $urandom_range(0, 59),
                                              $urandom_range(0, 59)));
          endcase
        end
        3: begin
          pending_stamps.push_back(stamp($urandom_range(1970, 36000), $urandom_range(1, 12),
                                         $urandom_range(1, 28), $urandom_range(0, 23),
                                         $urandom_range(0, 59), $urandom_range(0, 59)));
        end
        default: pending_stamps.push_back(40'($urandom()));
      endcase
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Hold until every request is taken and every result is back.
    while (pending_stamps.size() != 0 || s_axis_tvalid_i || expected_dates.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (!failed) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #(12 * 400000);
    $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire
